[rtl/fna_pkg.sv]
// Shared types, codes and helpers for the nodal force accumulator.
`default_nettype none
package fna_pkg;
	typedef logic [1:0] mode_t;
	typedef logic [1:0] status_t;

	localparam mode_t MODE_FACE = 2'd0;
	localparam mode_t MODE_BODY = 2'd1;
	localparam mode_t MODE_READ = 2'd2;

	localparam status_t ST_ADDED = 2'd0;
	localparam status_t ST_SKIPPED = 2'd1;
	localparam status_t ST_READ = 2'd2;

	localparam logic [1:0] REG_BFX = 2'd0;
	localparam logic [1:0] REG_BFY = 2'd1;
	localparam logic [1:0] REG_BFZ = 2'd2;
	localparam logic [1:0] REG_DENS = 2'd3;

	localparam int DIV_W = 48;
	localparam logic [32:0] DELTA_CAP = 33'h1_0000_0000;
	// (2^27 + 1) / 3: exact floor(y / 3) for any y below 2^27
	localparam logic [25:0] DIV3_RECIP = 26'd44739243;

	function automatic logic [31:0] abs32(input logic [31:0] x);
		abs32 = x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic logic [23:0] div3(input logic [25:0] y);
		logic [51:0] p;
		p = {26'b0, y} * {26'b0, DIV3_RECIP};
		div3 = p[50:27];
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic neg,
		input logic [32:0] m);
		logic signed [34:0] s;
		logic signed [34:0] d;
		d = $signed({2'b00, m});
		if (neg) begin
			d = -d;
		end
		s = $signed({{3{a[31]}}, a}) + d;
		if (s > 35'sd2147483647) begin
			sat_add = 32'h7FFF_FFFF;
		end else if (s < -35'sd2147483648) begin
			sat_add = 32'h8000_0000;
		end else begin
			sat_add = s[31:0];
		end
	endfunction
endpackage
`default_nettype wire

[rtl/fna_ram.sv]
// Generic single-clock RAM with one write port and a registered read port.
`default_nettype none
module fna_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4096
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/fna_div.sv]
// Restoring shift-subtract divider, one quotient bit per cycle.
`default_nettype none
module fna_div
	import fna_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [DIV_W-1:0] dividend,
	input wire logic [31:0] divisor,
	output logic done,
	output logic [DIV_W-1:0] quotient
);
	logic run_q;
	logic [5:0] cnt_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;

	assign trial = {rem_q, quotient[DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				quotient <= dividend;
				dvs_q <= divisor;
				rem_q <= '0;
				cnt_q <= 6'(DIV_W - 1);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (trial >= {1'b0, dvs_q}) begin
					rem_q <= 32'(trial - {1'b0, dvs_q});
					quotient <= {quotient[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[31:0];
					quotient <= {quotient[DIV_W-2:0], 1'b0};
				end
				if (cnt_q == 6'd0) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end
endmodule
`default_nettype wire

[rtl/fem_nodal_force_accumulator_core.sv]
// Top level: nodal force store with face and body load accumulation.
// Face: three plane squares, 32-step root, 4-step divide by 3, three normal/scale passes
// with 48-step divides, a write per vertex; body: three scale passes, a write per vertex.
// Zero-normal faces and unused modes finish from idle with busy low; a vertex outside
// the store skips its write. One item at a time, busy high from transfer until done;
// the receiver cannot stall done. Reset clears the store one entry per cycle, busy high.
`default_nettype none
module fem_nodal_force_accumulator_core
	import fna_pkg::*;
#(
	parameter int NODE_COUNT = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] mode,
	input wire logic [11:0] first_vertex,
	input wire logic [11:0] second_vertex,
	input wire logic [11:0] third_vertex,
	input wire logic [11:0] fourth_vertex,
	input wire logic signed [31:0] plane_b,
	input wire logic signed [31:0] plane_c,
	input wire logic signed [31:0] plane_d,
	input wire logic [31:0] face_area,
	input wire logic signed [31:0] traction,
	input wire logic [31:0] element_volume,
	output logic done,
	output logic [1:0] status,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z
);
	localparam int AW = $clog2(NODE_COUNT);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_SQ, S_SQRT, S_TMUL, S_TDIV, S_TDIVW, S_TDIV2, S_NDIV, S_NDIVW,
		S_BMUL, S_BSH, S_MLO, S_MHI, S_MCMB, S_ADDR, S_ADDW, S_RDR, S_RDW
	} state_t;

	state_t state_q;

	logic [31:0] bf_q [3];
	logic [31:0] dens_q;

	logic [1:0] mode_q;
	logic [11:0] vtx_q [4];
	logic [31:0] pl_q [3];
	logic [31:0] t_q;
	logic [31:0] area_q;
	logic [31:0] vol_q;

	logic [AW-1:0] clr_q;
	logic [5:0] cnt_q;
	logic [1:0] k_q;
	logic [1:0] vi_q;
	logic [63:0] sum_q;
	logic [63:0] rad_q;
	logic [32:0] rem_q;
	logic [31:0] root_q;
	logic [46:0] tx_q;
	logic [45:0] ma_q;
	logic [32:0] b_q;
	logic [47:0] lo_q;
	logic [32:0] mag_q [3];
	logic neg_q [3];
	logic [65:0] mul_q;

	logic [32:0] mul_a;
	logic [32:0] mul_b;
	logic [1:0] ksq;
	logic [63:0] sum_next;
	logic [34:0] sq_t;
	logic [34:0] sq_trial;
	logic [25:0] d3_y;
	logic [23:0] d3_q;
	logic [25:0] d3_r;
	logic [46:0] hi_w;
	logic [48:0] comb_r;
	logic [32:0] mag_w;
	logic [11:0] cur_v;
	logic cur_ok;
	logic [1:0] last_vi;

	logic div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [31:0] div_divisor;
	logic div_done;
	logic [DIV_W-1:0] div_quo;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [95:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [95:0] ram_rdata;

	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		case (paddr[3:2])
			REG_BFX: prdata = bf_q[0];
			REG_BFY: prdata = bf_q[1];
			REG_BFZ: prdata = bf_q[2];
			REG_DENS: prdata = dens_q;
			default: prdata = '0;
		endcase
	end

	assign ksq = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
	assign sum_next = sum_q + mul_q[63:0];
	assign sq_t = {rem_q, rad_q[63:62]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign d3_y = (state_q == S_TDIVW) ? {3'b0, tx_q[46:24]} : tx_q[25:0];
	assign d3_q = div3(d3_y);
	assign d3_r = d3_y - {1'b0, d3_q, 1'b0} - {2'b0, d3_q};
	assign hi_w = mul_q[46:0];
	assign comb_r = {17'b0, hi_w[15:0], 16'b0} + {1'b0, lo_q};
	assign mag_w = (hi_w >= 47'd65536 || comb_r > {16'b0, DELTA_CAP}) ? DELTA_CAP
		: comb_r[32:0];
	assign cur_v = (state_q == S_RDR || state_q == S_RDW) ? vtx_q[0] : vtx_q[vi_q];
	assign cur_ok = {5'b0, cur_v} < 17'(NODE_COUNT);
	assign last_vi = (mode_q == MODE_FACE) ? 2'd2 : 2'd3;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				mul_a = {1'b0, abs32(pl_q[ksq])};
				mul_b = {1'b0, abs32(pl_q[ksq])};
			end
			S_TMUL: begin
				mul_a = {1'b0, abs32(t_q)};
				mul_b = {1'b0, area_q};
			end
			S_BMUL: begin
				mul_a = {1'b0, dens_q};
				mul_b = {1'b0, vol_q};
			end
			S_MLO: begin
				mul_a = {1'b0, ma_q[31:0]};
				mul_b = b_q;
			end
			S_MHI: begin
				mul_a = {19'b0, ma_q[45:32]};
				mul_b = b_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = (state_q == S_NDIV);
	assign div_dividend = {abs32(pl_q[k_q]), 16'b0} + {17'b0, root_q[31:1]};
	assign div_divisor = root_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = AW'(cur_v);
		ram_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
			end
			S_ADDW: begin
				ram_we = 1'b1;
				ram_wdata = {sat_add(ram_rdata[95:64], neg_q[2], mag_q[2]),
					sat_add(ram_rdata[63:32], neg_q[1], mag_q[1]),
					sat_add(ram_rdata[31:0], neg_q[0], mag_q[0])};
			end
			S_RDW: begin
				ram_we = 1'b1;
			end
			default: ram_we = 1'b0;
		endcase
	end
	assign ram_raddr = AW'(cur_v);

	fna_ram #(.WIDTH(96), .DEPTH(NODE_COUNT)) u_store (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	fna_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bf_q[0] <= '0;
			bf_q[1] <= '0;
			bf_q[2] <= '0;
			dens_q <= 32'd65536;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BFX: bf_q[0] <= pwdata;
				REG_BFY: bf_q[1] <= pwdata;
				REG_BFZ: bf_q[2] <= pwdata;
				REG_DENS: dens_q <= pwdata;
				default: dens_q <= dens_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			done <= 1'b0;
			status <= ST_ADDED;
			cnt_q <= '0;
			k_q <= '0;
			vi_q <= '0;
		end else begin
			done <= 1'b0;
			mul_q <= mul_a * mul_b;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NODE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						mode_q <= mode;
						vtx_q[0] <= first_vertex;
						vtx_q[1] <= second_vertex;
						vtx_q[2] <= third_vertex;
						vtx_q[3] <= fourth_vertex;
						pl_q[0] <= plane_b;
						pl_q[1] <= plane_c;
						pl_q[2] <= plane_d;
						t_q <= traction;
						area_q <= face_area;
						vol_q <= element_volume;
						cnt_q <= '0;
						k_q <= '0;
						vi_q <= '0;
						sum_q <= '0;
						case (mode)
							MODE_FACE: begin
								if (plane_b == 0 && plane_c == 0 && plane_d == 0) begin
									done <= 1'b1;
									status <= ST_SKIPPED;
									force_x <= '0;
									force_y <= '0;
									force_z <= '0;
								end else begin
									state_q <= S_SQ;
								end
							end
							MODE_BODY: state_q <= S_BMUL;
							MODE_READ: state_q <= S_RDR;
							default: begin
								done <= 1'b1;
								status <= ST_ADDED;
								force_x <= '0;
								force_y <= '0;
								force_z <= '0;
							end
						endcase
					end
				end
				S_SQ: begin
					if (cnt_q != 6'd0) begin
						sum_q <= sum_next;
					end
					if (cnt_q == 6'd3) begin
						rad_q <= sum_next;
						rem_q <= '0;
						root_q <= '0;
						cnt_q <= '0;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_SQRT: begin
					if (sq_t >= sq_trial) begin
						rem_q <= 33'(sq_t - sq_trial);
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q <= sq_t[32:0];
						root_q <= {root_q[30:0], 1'b0};
					end
					rad_q <= {rad_q[61:0], 2'b00};
					if (cnt_q == 6'd31) begin
						state_q <= S_TMUL;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				S_TMUL: state_q <= S_TDIV;
				S_TDIV: begin
					tx_q <= 47'((mul_q[62:0] + 63'd98304) >> 16);
					state_q <= S_TDIVW;
				end
				S_TDIVW: begin
					ma_q <= {d3_q[21:0], 24'b0};
					tx_q <= {21'b0, d3_r[1:0], tx_q[23:0]};
					state_q <= S_TDIV2;
				end
				S_TDIV2: begin
					ma_q <= {ma_q[45:24], d3_q};
					k_q <= '0;
					state_q <= S_NDIV;
				end
				S_NDIV: state_q <= S_NDIVW;
				S_NDIVW: begin
					if (div_done) begin
						b_q <= {16'b0, div_quo[16:0]};
						state_q <= S_MLO;
					end
				end
				S_BMUL: state_q <= S_BSH;
				S_BSH: begin
					ma_q <= 46'((mul_q[63:0] + 64'd131072) >> 18);
					b_q <= {1'b0, abs32(bf_q[0])};
					k_q <= '0;
					state_q <= S_MLO;
				end
				S_MLO: state_q <= S_MHI;
				S_MHI: begin
					lo_q <= 48'((mul_q[63:0] + 64'h8000) >> 16);
					state_q <= S_MCMB;
				end
				S_MCMB: begin
					mag_q[k_q] <= mag_w;
					if (mode_q == MODE_FACE) begin
						neg_q[k_q] <= (pl_q[k_q][31] == t_q[31]);
					end else begin
						neg_q[k_q] <= bf_q[k_q][31];
					end
					if (k_q == 2'd2) begin
						vi_q <= '0;
						state_q <= S_ADDR;
					end else begin
						k_q <= k_q + 2'd1;
						if (mode_q == MODE_FACE) begin
							state_q <= S_NDIV;
						end else begin
							b_q <= {1'b0, abs32(bf_q[k_q + 2'd1])};
							state_q <= S_MLO;
						end
					end
				end
				S_ADDR: begin
					if (cur_ok) begin
						state_q <= S_ADDW;
					end else if (vi_q == last_vi) begin
						done <= 1'b1;
						status <= ST_ADDED;
						force_x <= '0;
						force_y <= '0;
						force_z <= '0;
						state_q <= S_IDLE;
					end else begin
						vi_q <= vi_q + 2'd1;
					end
				end
				S_ADDW: begin
					if (vi_q == last_vi) begin
						done <= 1'b1;
						status <= ST_ADDED;
						force_x <= '0;
						force_y <= '0;
						force_z <= '0;
						state_q <= S_IDLE;
					end else begin
						vi_q <= vi_q + 2'd1;
						state_q <= S_ADDR;
					end
				end
				S_RDR: begin
					if (cur_ok) begin
						state_q <= S_RDW;
					end else begin
						done <= 1'b1;
						status <= ST_READ;
						force_x <= '0;
						force_y <= '0;
						force_z <= '0;
						state_q <= S_IDLE;
					end
				end
				S_RDW: begin
					done <= 1'b1;
					status <= ST_READ;
					force_x <= ram_rdata[31:0];
					force_y <= ram_rdata[63:32];
					force_z <= ram_rdata[95:64];
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/fna_check.sv]
// Port-level checker for the accumulator core, bound to the top level.
`default_nettype none
module fna_check
	import fna_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [1:0] status,
	input wire logic signed [31:0] force_x,
	input wire logic signed [31:0] force_y,
	input wire logic signed [31:0] force_z
);
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("transfer not taken up");

	a_zero_forces: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_READ) |-> (force_x == 0 && force_y == 0 && force_z == 0))
		else $error("nonzero force on non-read result");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start)) else $error("result without transfer");
endmodule

bind fem_nodal_force_accumulator_core fna_check u_fna_check (.*);
`default_nettype wire

[tb/sv/fem_nodal_force_accumulator_checker.sv]
// Checker: watches the register port, item transfers and result strobes, predicts and compares.
`timescale 1ns / 1ps
module fem_nodal_force_accumulator_checker
	import fna_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	input wire logic pready,
	input wire logic start,
	input wire logic busy,
	input wire logic [1:0] mode,
	input wire logic [11:0] first_vertex,
	input wire logic [11:0] second_vertex,
	input wire logic [11:0] third_vertex,
	input wire logic [11:0] fourth_vertex,
	input wire logic signed [31:0] plane_b,
	input wire logic signed [31:0] plane_c,
	input wire logic signed [31:0] plane_d,
	input wire logic [31:0] face_area,
	input wire logic signed [31:0] traction,
	input wire logic [31:0] element_volume,
	input wire logic done,
	input wire logic [1:0] status,
	input wire logic signed [31:0] force_x,
	input wire logic signed [31:0] force_y,
	input wire logic signed [31:0] force_z,
	output int pending,
	output int fails
);
	localparam int NODES = 4096;
	localparam logic [63:0] LOAD_CAP = 64'h1_0000_0000;

	typedef struct packed {
		status_t st;
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fz;
	} node_result_t;

	node_result_t result_q[$];
	logic signed [31:0] node_force [NODES][3];
	logic signed [31:0] bf [3];
	logic [31:0] dens;

	function automatic logic [63:0] mag_of(input logic [31:0] v);
		longint s;
		s = longint'($signed(v));
		return (s < 0) ? 64'(-s) : 64'(s);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - r - b;
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] scale_q16(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b} + 128'h8000) >> 16;
		return (p > {64'd0, LOAD_CAP}) ? LOAD_CAP : p[63:0];
	endfunction

	function automatic void accumulate(input logic [11:0] idx, input int ax, input logic neg,
		input logic [63:0] m);
		longint s;
		if (idx >= NODES) return;
		s = longint'(node_force[idx][ax]) + (neg ? -longint'(m) : longint'(m));
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		node_force[idx][ax] = s[31:0];
	endfunction

	function automatic node_result_t predict_transfer();
		node_result_t r;
		logic [11:0] vx [4];
		logic [31:0] pl [3];
		logic [63:0] sum, root, m, n, mult;
		logic [63:0] mg [3];
		logic ng [3];
		r = '0;
		r.st = ST_ADDED;
		vx[0] = first_vertex;
		vx[1] = second_vertex;
		vx[2] = third_vertex;
		vx[3] = fourth_vertex;
		pl[0] = plane_b;
		pl[1] = plane_c;
		pl[2] = plane_d;
		case (mode)
			MODE_FACE: begin
				sum = 0;
				for (int k = 0; k < 3; k++) sum += mag_of(pl[k]) * mag_of(pl[k]);
				if (sum == 0) begin
					r.st = ST_SKIPPED;
				end else begin
					root = int_sqrt(sum);
					m = (mag_of(traction) * {32'd0, face_area} + 64'd98304) / 64'd196608;
					for (int k = 0; k < 3; k++) begin
						n = ((mag_of(pl[k]) << 16) + (root >> 1)) / root;
						mg[k] = scale_q16(m, n);
						ng[k] = !(pl[k][31] != traction[31]);
					end
					for (int i = 0; i < 3; i++)
						for (int k = 0; k < 3; k++) accumulate(vx[i], k, ng[k], mg[k]);
				end
			end
			MODE_BODY: begin
				mult = ({32'd0, dens} * {32'd0, element_volume} + 64'd131072) >> 18;
				for (int k = 0; k < 3; k++) mg[k] = scale_q16(mult, mag_of(bf[k]));
				for (int i = 0; i < 4; i++)
					for (int k = 0; k < 3; k++) accumulate(vx[i], k, bf[k][31], mg[k]);
			end
			MODE_READ: begin
				r.st = ST_READ;
				if (first_vertex < NODES) begin
					r.fx = node_force[first_vertex][0];
					r.fy = node_force[first_vertex][1];
					r.fz = node_force[first_vertex][2];
					for (int k = 0; k < 3; k++) node_force[first_vertex][k] = '0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		node_result_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++)
				for (int k = 0; k < 3; k++) node_force[i][k] = '0;
			for (int k = 0; k < 3; k++) bf[k] = '0;
			dens = 32'h0001_0000;
			result_q.delete();
			pending = 0;
			fails = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_BFX: bf[0] = pwdata;
					REG_BFY: bf[1] = pwdata;
					REG_BFZ: bf[2] = pwdata;
					REG_DENS: dens = pwdata;
					default: ;
				endcase
			end
			if (done) begin
				got = '{status, force_x, force_y, force_z};
				if (result_q.size() == 0) begin
					$error("result with no expectation waiting: status %0d", status);
					fails++;
				end else begin
					want = result_q.pop_front();
					if (got.st !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, got.st);
						fails++;
					end
					if (got.fx !== want.fx) begin
						$error("force_x: expected %h, got %h", want.fx, got.fx);
						fails++;
					end
					if (got.fy !== want.fy) begin
						$error("force_y: expected %h, got %h", want.fy, got.fy);
						fails++;
					end
					if (got.fz !== want.fz) begin
						$error("force_z: expected %h, got %h", want.fz, got.fz);
						fails++;
					end
				end
			end
			if (start && !busy) result_q.push_back(predict_transfer());
			pending = result_q.size();
		end
	end
endmodule

[tb/sv/fem_nodal_force_accumulator_core_test.sv]
// Testbench top: stimulus, register setup, idling phases and verdict for the force accumulator.
`timescale 1ns / 1ps
module fem_nodal_force_accumulator_core_test;
	import fna_pkg::*;

	localparam mode_t MODE_SPARE = 2'd3;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int PHASE_ITEMS = 560;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [1:0] mode = '0;
	logic [11:0] first_vertex = '0, second_vertex = '0, third_vertex = '0, fourth_vertex = '0;
	logic signed [31:0] plane_b = '0, plane_c = '0, plane_d = '0, traction = '0;
	logic [31:0] face_area = '0, element_volume = '0;
	logic done;
	logic [1:0] status;
	logic signed [31:0] force_x, force_y, force_z;
	int pending, fails;
	longint cycles = 0;
	int n_face = 0, n_body = 0, n_read = 0, n_spare = 0;
	int idle_pct = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	fem_nodal_force_accumulator_core dut (.*);
	fem_nodal_force_accumulator_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic wait_idle();
		do @(posedge clk); while (busy || pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_body(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
		input logic [31:0] d);
		write_reg(REG_BFX, x);
		write_reg(REG_BFY, y);
		write_reg(REG_BFZ, z);
		write_reg(REG_DENS, d);
	endtask

	// drive one item and hold it until the transfer edge
	task automatic issue(input mode_t md, input logic [11:0] v0, input logic [11:0] v1,
		input logic [11:0] v2, input logic [11:0] v3, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d, input logic [31:0] area,
		input logic [31:0] trac, input logic [31:0] vol);
		mode <= md;
		first_vertex <= v0;
		second_vertex <= v1;
		third_vertex <= v2;
		fourth_vertex <= v3;
		plane_b <= b;
		plane_c <= c;
		plane_d <= d;
		face_area <= area;
		traction <= trac;
		element_volume <= vol;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		case (md)
			MODE_FACE: n_face++;
			MODE_BODY: n_body++;
			MODE_READ: n_read++;
			default: n_spare++;
		endcase
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	function automatic logic [11:0] pick_vertex();
		return ($urandom_range(99) < 75) ? 12'($urandom_range(0, 23)) : 12'($urandom);
	endfunction

	function automatic logic [31:0] pick_coef();
		int r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 70) return 32'($signed(32'($urandom_range(0, 32'h3_0000))) - 32'sh1_8000);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_pos();
		return ($urandom_range(99) < 70) ? 32'($urandom_range(0, 32'h8_0000)) : $urandom;
	endfunction

	task automatic random_phase(input int pct);
		int r;
		logic [31:0] b, c, d;
		idle_pct = pct;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			r = $urandom_range(99);
			if (r < 40) begin
				b = pick_coef();
				c = pick_coef();
				d = pick_coef();
				if ($urandom_range(19) == 0) begin
					b = '0;
					c = '0;
					d = '0;
				end
				issue(MODE_FACE, pick_vertex(), pick_vertex(), pick_vertex(), 12'($urandom),
					b, c, d, pick_pos(), pick_coef(), $urandom);
			end else if (r < 70) begin
				issue(MODE_BODY, pick_vertex(), pick_vertex(), pick_vertex(), pick_vertex(),
					$urandom, $urandom, $urandom, $urandom, $urandom, pick_pos());
			end else if (r < 96) begin
				issue(MODE_READ, pick_vertex(), 12'($urandom), 12'($urandom), 12'($urandom),
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				issue(MODE_SPARE, pick_vertex(), pick_vertex(), pick_vertex(), pick_vertex(),
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
		end
		start <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		set_body(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF);
		issue(MODE_FACE, 12'd0, 12'd1, 12'd2, 12'd0, 32'h0001_0000, 32'h0, 32'h0,
			32'h0001_0000, 32'h0003_0000, 32'h0);
		issue(MODE_FACE, 12'd3, 12'd3, 12'd3, 12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue(MODE_FACE, 12'd4, 12'd5, 12'hFFF, 12'd0, 32'hFFFF_0000, 32'h0000_8000,
			32'h0000_0001, 32'h0002_0000, 32'h8000_0000, 32'h0);
		issue(MODE_FACE, 12'd6, 12'd7, 12'd8, 12'd9, 32'h0, 32'h0, 32'h0,
			32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0);
		issue(MODE_FACE, 12'd6, 12'd7, 12'd8, 12'd9, 32'h0, 32'h0, 32'h0000_0001,
			32'h0, 32'h0, 32'h0);
		issue(MODE_BODY, 12'd10, 12'd10, 12'd11, 12'hFFF, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'hFFFF_FFFF);
		issue(MODE_BODY, 12'd12, 12'd13, 12'd14, 12'd15, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0);
		issue(MODE_BODY, 12'd0, 12'd1, 12'd2, 12'd3, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0000_0001);
		issue(MODE_SPARE, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int v = 0; v < 16; v++)
			issue(MODE_READ, 12'(v), 12'hFFF, 12'h0, 12'hFFF, 32'h0, 32'h0, 32'h0,
				32'h0, 32'h0, 32'h0);
		issue(MODE_READ, 12'hFFF, 12'h0, 12'h0, 12'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0);
		start <= 1'b0;
		wait_idle();

		set_body(32'h0000_2000, 32'hFFFF_C000, 32'h0001_8000, 32'h0001_0000);
		random_phase(18);
		wait_idle();
		set_body($urandom, $urandom, $urandom, $urandom);
		random_phase(80);
		wait_idle();
		set_body(32'h0, 32'h0, 32'h8000_0000, 32'h0);
		random_phase(0);

		do @(posedge clk); while (busy || pending != 0);
		repeat (300) @(posedge clk);
		$display("Transfers: %0d traction faces, %0d body elements, %0d reads, %0d unused-mode",
			n_face, n_body, n_read, n_spare);
		$display("Body load settings: extremes, mild, random, zero density; %0d cycles", cycles);
		if (fails == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

[files.f]
rtl/fna_pkg.sv
rtl/fna_ram.sv
rtl/fna_div.sv
rtl/fem_nodal_force_accumulator_core.sv
rtl/fna_check.sv
tb/sv/fem_nodal_force_accumulator_checker.sv
tb/sv/fem_nodal_force_accumulator_core_test.sv
